// ===== src/adsr_pkg.sv =====
// Package for the linear ADSR envelope generator.
// Holds the phase and sequencer types, field widths, register indexes and constants.
// Has no dependencies of its own.
package adsr_pkg;

  // Field widths.
  localparam int unsigned LEVEL_W   = 17;
  localparam int unsigned TIME_W    = 24;
  localparam int unsigned DT_W      = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // Divider widths: the dividend is elapsed time times a 17-bit level span.
  localparam int unsigned NUM_W = DT_W + LEVEL_W;
  localparam int unsigned REM_W = TIME_W + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W);
  localparam int unsigned SUM_W = NUM_W + 1;

  // Level full scale (1.0 in Q1.16) and the shortest phase time.
  localparam logic [LEVEL_W-1:0] FULL_SCALE  = LEVEL_W'(65536);
  localparam logic [TIME_W-1:0]  MIN_TIME_US = TIME_W'(1000);

  // Configuration register reset values.
  localparam logic [TIME_W-1:0]  ATTACK_RST  = TIME_W'(10000);
  localparam logic [TIME_W-1:0]  DECAY_RST   = TIME_W'(10000);
  localparam logic [LEVEL_W-1:0] SUSTAIN_RST = LEVEL_W'(49152);
  localparam logic [TIME_W-1:0]  RELEASE_RST = TIME_W'(10000);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(3);

  // Request kinds carried in the mode field.
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_GATE = 1'b1;

  // Envelope phase.
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  // Sequencer state.
  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_PREP,
    SQ_DIV,
    SQ_APPLY,
    SQ_DONE
  } seq_e;

endpackage

// ===== src/adsr_envelope_generator.sv =====
// Linear ADSR envelope generator, top level.
// Uses adsr_pkg for types and constants; the step divider is a shared restoring unit.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | to block  | in_valid_i/in_ready_o  | mode_i, gate_on_i, elapsed_us_i
//   out     | from block| out_valid_o/out_ready_i| level_o, phase_o
//   cfg     | to block  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A tick in attack, decay or release goes from request to result in these steps: latch
// the request, form the dividend, run the bit-serial divider (one quotient bit per
// cycle), update the envelope and load the output register.
// Gate events and ticks in idle or sustain skip the divider. The next request is taken once
// the sequencer is back in idle, even if the last result still waits in the output
// register; a stalled output holds the sequencer in its final state.
// Reset clears the envelope to idle at level zero and loads the default configuration.
module adsr_envelope_generator
  import adsr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input requests.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic                 gate_on_i,
  input  logic [DT_W-1:0]      elapsed_us_i,
  // Results.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [LEVEL_W-1:0]   level_o,
  output logic [2:0]           phase_o,
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [TIME_W-1:0]  attack_q, decay_q, release_q;
  logic [LEVEL_W-1:0] sustain_q;

  // Envelope state.
  phase_e             phase_q, phase_d;
  logic [LEVEL_W-1:0] level_q, level_d;

  // Sequencer and latched request.
  seq_e               seq_q, seq_d;
  logic               mode_q, gate_q;
  logic [DT_W-1:0]    dt_q;

  // Divider registers: the dividend register collects the quotient as it shifts.
  logic [NUM_W-1:0]   num_q, num_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic [TIME_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] out_level_q;
  phase_e             out_phase_q;
  logic               out_load;

  // Combinational helpers.
  logic [LEVEL_W-1:0] sus_sat;
  logic [LEVEL_W-1:0] span;
  logic [TIME_W-1:0]  phase_time;
  logic [TIME_W-1:0]  div_floor;
  logic [NUM_W-1:0]   product;
  logic               needs_div;
  logic [REM_W-1:0]   rem_shift;
  logic               q_bit;
  logic [SUM_W-1:0]   step_ext, lvl_ext, sus_ext;
  logic [SUM_W-1:0]   attack_sum, decay_bound;
  logic               active;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (seq_q == SQ_IDLE);

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= ATTACK_RST;
      decay_q   <= DECAY_RST;
      sustain_q <= SUSTAIN_RST;
      release_q <= RELEASE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ATTACK:  attack_q  <= cfg_data_i[TIME_W-1:0];
        CFG_DECAY:   decay_q   <= cfg_data_i[TIME_W-1:0];
        CFG_SUSTAIN: sustain_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_RELEASE: release_q <= cfg_data_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Sustain level saturated to full scale, and the level span of the current phase.
  assign sus_sat = (sustain_q > FULL_SCALE) ? FULL_SCALE : sustain_q;
  assign span    = (phase_q == PH_DECAY) ? (FULL_SCALE - sus_sat) : FULL_SCALE;

  // Phase time, floored at the shortest allowed duration.
  always_comb begin
    case (phase_q)
      PH_ATTACK: phase_time = attack_q;
      PH_DECAY:  phase_time = decay_q;
      default:   phase_time = release_q;
    endcase
  end
  assign div_floor = (phase_time < MIN_TIME_US) ? MIN_TIME_US : phase_time;

  // Dividend: elapsed time times the level span.
  assign product = NUM_W'(dt_q) * NUM_W'(span);

  // Only ticks in a moving phase need a step.
  always_comb begin
    needs_div = 1'b0;
    if (mode_q == MODE_TICK) begin
      needs_div = phase_q inside {PH_ATTACK, PH_DECAY, PH_RELEASE};
    end
  end

  // One restoring divider step: shift in the next dividend bit, subtract when it fits.
  assign rem_shift = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
  assign q_bit     = (rem_shift >= REM_W'(div_q));

  // Step comparisons, carried one bit wider than the quotient.
  assign step_ext    = SUM_W'(num_q);
  assign lvl_ext     = SUM_W'(level_q);
  assign sus_ext     = SUM_W'(sus_sat);
  assign attack_sum  = lvl_ext + step_ext;
  assign decay_bound = step_ext + sus_ext;
  assign active      = phase_q inside {PH_ATTACK, PH_DECAY, PH_SUSTAIN};

  // Output register loads when the sequencer finishes and the slot is free.
  assign out_load = (seq_q == SQ_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer, divider and envelope update.
  always_comb begin
    seq_d       = seq_q;
    num_d       = num_q;
    rem_d       = rem_q;
    div_d       = div_q;
    cnt_d       = cnt_q;
    phase_d     = phase_q;
    level_d     = level_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (seq_q)
      SQ_IDLE: begin
        if (in_valid_i) begin
          seq_d = SQ_PREP;
        end
      end
      SQ_PREP: begin
        num_d = product;
        rem_d = '0;
        div_d = div_floor;
        cnt_d = CNT_W'(NUM_W - 1);
        seq_d = needs_div ? SQ_DIV : SQ_APPLY;
      end
      SQ_DIV: begin
        num_d = {num_q[NUM_W-2:0], q_bit};
        rem_d = q_bit ? (rem_shift - REM_W'(div_q)) : rem_shift;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          seq_d = SQ_APPLY;
        end
      end
      SQ_APPLY: begin
        seq_d = SQ_DONE;
        if (mode_q == MODE_GATE) begin
          if (gate_q && !active) begin
            phase_d = PH_ATTACK;
          end else if (!gate_q && active) begin
            phase_d = PH_RELEASE;
          end
        end else begin
          case (phase_q)
            PH_ATTACK: begin
              if (attack_sum >= SUM_W'(FULL_SCALE)) begin
                level_d = FULL_SCALE;
                phase_d = (decay_q != '0) ? PH_DECAY : PH_SUSTAIN;
              end else begin
                level_d = attack_sum[LEVEL_W-1:0];
              end
            end
            PH_DECAY: begin
              if (lvl_ext <= decay_bound) begin
                level_d = sus_sat;
                phase_d = PH_SUSTAIN;
              end else begin
                level_d = level_q - num_q[LEVEL_W-1:0];
              end
            end
            PH_RELEASE: begin
              if (lvl_ext <= step_ext) begin
                level_d = '0;
                phase_d = PH_IDLE;
              end else begin
                level_d = level_q - num_q[LEVEL_W-1:0];
              end
            end
            default: ;
          endcase
        end
      end
      SQ_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          seq_d       = SQ_IDLE;
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SQ_IDLE;
      phase_q     <= PH_IDLE;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      seq_q       <= seq_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  // Payload registers: latched request, divider datapath and result.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mode_q <= mode_i;
      gate_q <= gate_on_i;
      dt_q   <= elapsed_us_i;
    end
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
    if (out_load) begin
      out_level_q <= level_q;
      out_phase_q <= phase_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = out_level_q;
  assign phase_o     = out_phase_q;

`ifndef SYNTHESIS
  // The level never leaves the range zero to full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni) level_q <= FULL_SCALE)
    else $error("envelope level above full scale");

  // The idle phase is only reached with the level at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (level_q == '0))
    else $error("idle phase with non-zero level");

  // A taken request blocks the input until its result is formed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input ready right after a request");

  // The divider hands over to the update step after its last quotient bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_DIV && cnt_q == '0) |=> (seq_q == SQ_APPLY))
    else $error("divider did not finish on its last bit");
`endif

endmodule
